// ----- rtl/mrm_pkg.sv -----
`timescale 1ns / 1ps

package mrm_pkg;

  // Input opcodes
  localparam logic [1:0] OP_START_READ  = 2'd0;
  localparam logic [1:0] OP_START_WRITE = 2'd1;
  localparam logic [1:0] OP_RX_BYTE     = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX_BYTE   = 2'd0;
  localparam logic [1:0] KIND_READ_ACK  = 2'd1;
  localparam logic [1:0] KIND_WRITE_ACK = 2'd2;

  // Frame constants
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FC_READ        = 8'h03;
  localparam logic [7:0]  FC_WRITE       = 8'h06;
  localparam logic [7:0]  READ_COUNT     = 8'h02;
  localparam logic [7:0]  READ_QTY_HI    = 8'h00;
  localparam logic [7:0]  READ_QTY_LO    = 8'h01;
  localparam int          FRAME_LEN      = 8;
  localparam int          HEADER_LEN     = 6;
  localparam int          CNT_W          = $clog2(FRAME_LEN + 1);
  localparam int          IDX_W          = $clog2(FRAME_LEN);

  // One beat group handed to the output buffer
  typedef struct packed {
    logic [1:0]                     kind;
    logic [FRAME_LEN-1:0][7:0]      bytes;
    logic [15:0]                    value;
    logic [CNT_W-1:0]               count;
  } mrm_load_t;

  // Fold one byte into a running CRC-16, LSB first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrm_if.sv -----
`timescale 1ns / 1ps

interface mrm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  slave_address;
  logic [15:0] register_address;
  logic [15:0] write_value;
  logic [7:0]  rx_byte;

  modport source (output valid, opcode, slave_address, register_address, write_value,
                  rx_byte, input ready);
  modport sink   (input valid, opcode, slave_address, register_address, write_value,
                  rx_byte, output ready);
endinterface

interface mrm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic        last_byte;
  logic [15:0] read_value;

  modport source (output valid, result_kind, tx_byte, last_byte, read_value, input ready);
  modport sink   (input valid, result_kind, tx_byte, last_byte, read_value, output ready);
endinterface

// ----- rtl/modbus_rtu_register_master.sv -----
`timescale 1ns / 1ps
// Flow: an accepted item is registered in the input stage, then processed, and its
//   result beats are loaded into the output buffer, which offers them on out_o.
// Throughput: one item per cycle unless a result must wait for the output buffer; a start
//   item loads eight beats, so the next result waits until the final request byte leaves.
// Reset: asynchronous, active low; clears the input stage, the wait mode, the window
//   and the output buffer. No clearing pass.

module modbus_rtu_register_master (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrm_in_if.sink    in_i,
  mrm_out_if.source out_o
);

  // Wait modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam int FL = mrm_pkg::FRAME_LEN;
  localparam int HL = mrm_pkg::HEADER_LEN;

  // Input stage: hold one beat
  logic        in_vq;
  logic [1:0]  op_q;
  logic [7:0]  addr_q;
  logic [15:0] reg_q;
  logic [15:0] wval_q;
  logic [7:0]  rxb_q;

  // Block state
  logic [1:0]            mode_q, mode_d;
  logic [HL-1:0][7:0]    req_q, req_d;
  logic [FL-1:0][7:0]    win_q, win_d;
  logic [3:0]            fill_q, fill_d;

  // Processing
  logic [HL-1:0][7:0]    req_new;
  logic [FL-1:0][7:0]    win_sh;
  logic [3:0]            fill_inc;
  logic [15:0]           crc_tx, crc_rd, crc_wr;
  logic                  read_hit, write_hit;
  mrm_pkg::mrm_load_t    load;
  logic                  load_ok;
  logic                  fire;
  logic                  do_load;

  assign fire     = in_vq && (load_ok || (load.count == '0));
  assign do_load  = fire && (load.count != '0);
  assign in_i.ready = !in_vq || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q   <= in_i.opcode;
      addr_q <= in_i.slave_address;
      reg_q  <= in_i.register_address;
      wval_q <= in_i.write_value;
      rxb_q  <= in_i.rx_byte;
    end
  end

  // Build the request header and its CRC
  always_comb begin
    req_new[0] = addr_q;
    req_new[1] = (op_q == mrm_pkg::OP_START_READ) ? mrm_pkg::FC_READ : mrm_pkg::FC_WRITE;
    req_new[2] = reg_q[15:8];
    req_new[3] = reg_q[7:0];
    if (op_q == mrm_pkg::OP_START_READ) begin
      req_new[4] = mrm_pkg::READ_QTY_HI;
      req_new[5] = mrm_pkg::READ_QTY_LO;
    end else begin
      req_new[4] = wval_q[15:8];
      req_new[5] = wval_q[7:0];
    end
    crc_tx = mrm_pkg::CRC_INIT;
    for (int k = 0; k < HL; k++) begin
      crc_tx = mrm_pkg::crc16_update(crc_tx, req_new[k]);
    end
  end

  // Shift the received byte in; newest sits at the top index
  always_comb begin
    for (int k = 0; k < FL - 1; k++) begin
      win_sh[k] = win_q[k+1];
    end
    win_sh[FL-1] = rxb_q;
    fill_inc = (fill_q == 4'(FL)) ? fill_q : fill_q + 4'd1;

    // Read reply: seven newest bytes, CRC over the first five of them
    crc_rd = mrm_pkg::CRC_INIT;
    for (int k = 1; k < 6; k++) begin
      crc_rd = mrm_pkg::crc16_update(crc_rd, win_sh[k]);
    end
    // Write echo: full window, CRC over the six header bytes
    crc_wr = mrm_pkg::CRC_INIT;
    for (int k = 0; k < HL; k++) begin
      crc_wr = mrm_pkg::crc16_update(crc_wr, win_sh[k]);
    end

    read_hit = (fill_inc >= 4'd7) && (win_sh[1] == req_q[0]) && (win_sh[2] == req_q[1])
            && (win_sh[3] == mrm_pkg::READ_COUNT) && (crc_rd == {win_sh[7], win_sh[6]});
    write_hit = (fill_inc >= 4'(FL)) && (win_sh[HL-1:0] == req_q)
             && (crc_wr == {win_sh[7], win_sh[6]});
  end

  // Decide the next state and what goes to the output buffer
  always_comb begin
    mode_d = mode_q;
    req_d  = req_q;
    win_d  = win_q;
    fill_d = fill_q;
    load.kind  = mrm_pkg::KIND_TX_BYTE;
    load.bytes = {crc_tx[15:8], crc_tx[7:0], req_new};
    load.value = 16'h0000;
    load.count = '0;
    case (op_q)
      mrm_pkg::OP_START_READ, mrm_pkg::OP_START_WRITE: begin
        // abandon any pending request, clear the window, send the new frame
        load.count = mrm_pkg::CNT_W'(FL);
        req_d  = req_new;
        mode_d = (op_q == mrm_pkg::OP_START_READ) ? MODE_READ : MODE_WRITE;
        win_d  = '0;
        fill_d = '0;
      end
      mrm_pkg::OP_RX_BYTE: begin
        if (mode_q != MODE_IDLE) begin
          win_d  = win_sh;
          fill_d = fill_inc;
          if ((mode_q == MODE_READ) && read_hit) begin
            load.kind  = mrm_pkg::KIND_READ_ACK;
            load.value = {win_sh[4], win_sh[5]};
            load.count = mrm_pkg::CNT_W'(1);
            mode_d     = MODE_IDLE;
          end else if ((mode_q == MODE_WRITE) && write_hit) begin
            load.kind  = mrm_pkg::KIND_WRITE_ACK;
            load.count = mrm_pkg::CNT_W'(1);
            mode_d     = MODE_IDLE;
          end
        end
      end
      default: begin
        // unused opcode: drop the beat
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      req_q  <= '0;
      win_q  <= '0;
      fill_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      req_q  <= req_d;
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

  mrm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (do_load),
    .load_data_i (load),
    .load_ok_o   (load_ok),
    .out_o       (out_o)
  );

endmodule

// ----- rtl/mrm_out_buf.sv -----
`timescale 1ns / 1ps

module mrm_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mrm_pkg::mrm_load_t load_data_i,
  output logic              load_ok_o,
  mrm_out_if.source         out_o
);

  logic [1:0]                          kind_q;
  logic [mrm_pkg::FRAME_LEN-1:0][7:0]  bytes_q;
  logic [15:0]                         value_q;
  logic [mrm_pkg::CNT_W-1:0]           cnt_q, cnt_d;
  logic [mrm_pkg::IDX_W-1:0]           idx_q, idx_d;
  logic                                beat;
  logic                                is_tx;

  assign beat      = out_o.valid && out_o.ready;
  assign load_ok_o = (cnt_q == '0) || ((cnt_q == mrm_pkg::CNT_W'(1)) && out_o.ready);
  assign is_tx     = (kind_q == mrm_pkg::KIND_TX_BYTE);

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.result_kind = kind_q;
  assign out_o.tx_byte     = is_tx ? bytes_q[idx_q] : 8'h00;
  assign out_o.last_byte   = is_tx && (idx_q == mrm_pkg::IDX_W'(mrm_pkg::FRAME_LEN - 1));
  assign out_o.read_value  = value_q;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = load_data_i.count;
      idx_d = '0;
    end else if (beat) begin
      // advance to the next beat
      cnt_d = cnt_q - mrm_pkg::CNT_W'(1);
      idx_d = idx_q + mrm_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q  <= load_data_i.kind;
      bytes_q <= load_data_i.bytes;
      value_q <= load_data_i.value;
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the single-register Modbus RTU master.
// A software copy of the master runs beside the block: every accepted input item
// advances that copy, which queues the beats the block owes; a monitor pops and
// compares each output beat as it is accepted.

module tb;

  // Opcode 3 has no meaning; the block must swallow it silently
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    WAIT_IDLE  = 2'd0,
    WAIT_READ  = 2'd1,
    WAIT_WRITE = 2'd2
  } wait_e;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic        last;
    logic [15:0] value;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  mrm_in_if  in_if ();
  mrm_out_if out_if ();

  modbus_rtu_register_master u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow state of the master
  wait_e           shadow_mode;
  logic [7:0][7:0] shadow_request;  // bytes 0..5 hold the last request header
  logic [7:0][7:0] shadow_window;   // newest received byte at index 7
  int unsigned     shadow_fill;

  beat_t awaited_beats[$];

  // Run control shared between the stimulus, the receiver and the monitor
  bit          calm;          // last part of the run: no idling on either side
  bit          sender_bursty;
  bit          receiver_bursty;
  int unsigned hold_cycles;   // nonzero asks the receiver for one long stall

  int unsigned errors;
  int unsigned items_sent;
  int unsigned tx_beats;
  int unsigned read_acks;
  int unsigned write_acks;

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // CRC-16 over n bytes of d starting at index first; reflected, init all ones
  function automatic logic [15:0] crc_of(input logic [7:0][7:0] d, input int first,
                                         input int n);
    logic [15:0] c;
    c = mrm_pkg::CRC_INIT;
    for (int k = first; k < first + n; k++) begin
      c = c ^ {8'h00, d[k]};
      for (int b = 0; b < 8; b++) begin
        c = c[0] ? ((c >> 1) ^ mrm_pkg::CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  // Eight request bytes for a start item: header, then CRC low, CRC high
  function automatic logic [7:0][7:0] request_frame(input logic [1:0] op,
                                                    input logic [7:0] addr,
                                                    input logic [15:0] reg_addr,
                                                    input logic [15:0] wval);
    logic [7:0][7:0] f;
    logic [15:0]     c;
    f    = '0;
    f[0] = addr;
    f[1] = (op == mrm_pkg::OP_START_READ) ? mrm_pkg::FC_READ : mrm_pkg::FC_WRITE;
    f[2] = reg_addr[15:8];
    f[3] = reg_addr[7:0];
    f[4] = (op == mrm_pkg::OP_START_READ) ? mrm_pkg::READ_QTY_HI : wval[15:8];
    f[5] = (op == mrm_pkg::OP_START_READ) ? mrm_pkg::READ_QTY_LO : wval[7:0];
    c    = crc_of(f, 0, mrm_pkg::HEADER_LEN);
    f[6] = c[7:0];
    f[7] = c[15:8];
    return f;
  endfunction

  // Advance the shadow master by one accepted item and queue the beats it owes
  task automatic step_master(input logic [1:0] op, input logic [7:0] addr,
                             input logic [15:0] reg_addr, input logic [15:0] wval,
                             input logic [7:0] rxb);
    logic [7:0][7:0] f;
    beat_t           b;
    bit              hit;
    f   = '0;
    hit = 1'b0;
    case (op)
      mrm_pkg::OP_START_READ, mrm_pkg::OP_START_WRITE: begin
        // A start always wins: abandon any pending reply and resend
        f = request_frame(op, addr, reg_addr, wval);
        for (int k = 0; k < mrm_pkg::FRAME_LEN; k++) begin
          b.kind  = mrm_pkg::KIND_TX_BYTE;
          b.tx    = f[k];
          b.last  = (k == mrm_pkg::FRAME_LEN - 1);
          b.value = 16'h0000;
          awaited_beats.push_back(b);
        end
        shadow_request = f;
        shadow_mode    = (op == mrm_pkg::OP_START_READ) ? WAIT_READ : WAIT_WRITE;
        shadow_window  = '0;
        shadow_fill    = 0;
      end
      mrm_pkg::OP_RX_BYTE: begin
        // Bytes are dropped while idle
        if (shadow_mode != WAIT_IDLE) begin
          shadow_window = {rxb, shadow_window[7:1]};
          if (shadow_fill < mrm_pkg::FRAME_LEN) shadow_fill++;
          b.tx   = 8'h00;
          b.last = 1'b0;
          if (shadow_mode == WAIT_READ) begin
            // Read reply lives in the seven newest bytes: addr, 03, 02, hi, lo, crc
            hit = (shadow_fill >= 7) && (shadow_window[1] == shadow_request[0]) &&
                  (shadow_window[2] == shadow_request[1]) &&
                  (shadow_window[3] == mrm_pkg::READ_COUNT) &&
                  (crc_of(shadow_window, 1, 5) == {shadow_window[7], shadow_window[6]});
            b.kind  = mrm_pkg::KIND_READ_ACK;
            b.value = {shadow_window[4], shadow_window[5]};
          end else begin
            // Write echo: full eight bytes, header identical to the request
            hit = (shadow_fill >= mrm_pkg::FRAME_LEN) &&
                  (shadow_window[5:0] == shadow_request[5:0]) &&
                  (crc_of(shadow_window, 0, mrm_pkg::HEADER_LEN) ==
                   {shadow_window[7], shadow_window[6]});
            b.kind  = mrm_pkg::KIND_WRITE_ACK;
            b.value = 16'h0000;
          end
          if (hit) begin
            awaited_beats.push_back(b);
            shadow_mode = WAIT_IDLE;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // Compare one accepted output beat against the oldest expectation
  task automatic check_beat();
    beat_t want;
    if (awaited_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat kind %0d tx %02h last %0b value %04h",
                                out_if.result_kind, out_if.tx_byte, out_if.last_byte,
                                out_if.read_value));
      return;
    end
    want = awaited_beats.pop_front();
    if (out_if.result_kind !== want.kind)
      report_mismatch($sformatf("result_kind %0d, want %0d", out_if.result_kind, want.kind));
    if (out_if.tx_byte !== want.tx)
      report_mismatch($sformatf("tx_byte %02h, want %02h", out_if.tx_byte, want.tx));
    if (out_if.last_byte !== want.last)
      report_mismatch($sformatf("last_byte %0b, want %0b", out_if.last_byte, want.last));
    if (out_if.read_value !== want.value)
      report_mismatch($sformatf("read_value %04h, want %04h", out_if.read_value, want.value));
    case (want.kind)
      mrm_pkg::KIND_TX_BYTE:  tx_beats++;
      mrm_pkg::KIND_READ_ACK: read_acks++;
      default:                write_acks++;
    endcase
  endtask

  // Monitor: sample the output handshake at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_beat();
  end

  // Receiver: drive ready at the falling edge; one long hold on request,
  // otherwise random stall bursts, and none in the calm tail
  initial begin
    int unsigned n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_if.ready = 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else if (!calm && receiver_bursty && $urandom_range(0, 4) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk_i);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Drive one item and hold it until accepted; valid stays high afterwards so the
  // next call can follow back to back
  task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                           input logic [15:0] reg_addr, input logic [15:0] wval,
                           input logic [7:0] rxb);
    @(negedge clk_i);
    if (!calm && sender_bursty && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_if.valid            = 1'b1;
    in_if.opcode           = op;
    in_if.slave_address    = addr;
    in_if.register_address = reg_addr;
    in_if.write_value      = wval;
    in_if.rx_byte          = rxb;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    step_master(op, addr, reg_addr, wval, rxb);
    items_sent++;
  endtask

  // Unused fields carry random junk so every input bit toggles
  task automatic send_rx(input logic [7:0] b);
    send_item(mrm_pkg::OP_RX_BYTE, 8'($urandom), 16'($urandom), 16'($urandom), b);
  endtask

  task automatic send_start(input logic [1:0] op, input logic [7:0] addr,
                            input logic [15:0] reg_addr, input logic [15:0] wval);
    send_item(op, addr, reg_addr, wval, 8'($urandom));
  endtask

  // Feed a slave reply; a flip_at inside the reply corrupts one bit of that byte
  task automatic send_reply(input logic [1:0] op, input logic [7:0] addr,
                            input logic [15:0] reg_addr, input logic [15:0] wval,
                            input logic [15:0] rval, input int flip_at);
    logic [7:0][7:0] f;
    logic [15:0]     c;
    int              len;
    if (op == mrm_pkg::OP_START_READ) begin
      f    = '0;
      f[0] = addr;
      f[1] = mrm_pkg::FC_READ;
      f[2] = mrm_pkg::READ_COUNT;
      f[3] = rval[15:8];
      f[4] = rval[7:0];
      c    = crc_of(f, 0, 5);
      f[5] = c[7:0];
      f[6] = c[15:8];
      len  = 7;
    end else begin
      f   = request_frame(op, addr, reg_addr, wval);
      len = mrm_pkg::FRAME_LEN;
    end
    if (flip_at >= 0 && flip_at < len) f[flip_at][$urandom_range(0, 7)] ^= 1'b1;
    for (int k = 0; k < len; k++) send_rx(f[k]);
  endtask

  // Drop valid and hold the input quiet
  task automatic quiet_input();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // Pause the sender until every owed beat has arrived, plus the block latency
  task automatic drain_results();
    int unsigned guard;
    guard = 0;
    quiet_input();
    while (awaited_beats.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  // Field values biased toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Bytes while idle and the unused opcode must produce nothing
  task automatic test_ignored_items();
    send_rx(8'hA5);
    send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
  endtask

  // Full read exchange at the low extremes, reply value all ones
  task automatic test_read_exchange();
    send_start(mrm_pkg::OP_START_READ, 8'h00, 16'h0000, 16'h0000);
    send_reply(mrm_pkg::OP_START_READ, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, -1);
  endtask

  // Full write exchange at the high extremes
  task automatic test_write_exchange();
    send_start(mrm_pkg::OP_START_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_reply(mrm_pkg::OP_START_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, -1);
  endtask

  // Start while waiting: the read is abandoned and the write goes out
  task automatic test_restart();
    send_start(mrm_pkg::OP_START_READ, 8'hAA, 16'h1234, 16'h0000);
    send_start(mrm_pkg::OP_START_WRITE, 8'h55, 16'h0000, 16'h0000);
  endtask

  // Stall the receiver for a long stretch while starts keep coming, so the
  // output buffer fills and the input backs up; then wait for everything
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int k = 0; k < 6; k++)
      send_start(2'($urandom_range(0, 1)), pick_byte(), pick_word(), pick_word());
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed exchanges with random content, mixed with
  // noise, corrupted replies, wrong-kind replies and abandoned requests
  // ---------------------------------------------------------------------------
  task automatic random_exchange();
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [15:0] reg_addr;
    logic [15:0] wval;
    logic [15:0] rval;
    int unsigned choice;
    op       = $urandom_range(0, 1) ? mrm_pkg::OP_START_WRITE : mrm_pkg::OP_START_READ;
    addr     = pick_byte();
    reg_addr = pick_word();
    wval     = pick_word();
    rval     = pick_word();
    sender_bursty   = $urandom_range(0, 2) != 0;
    receiver_bursty = $urandom_range(0, 2) != 0;
    send_start(op, addr, reg_addr, wval);
    choice = $urandom_range(0, 99);
    if (choice < 10) begin
      // Leave the matcher armed on noise; the next start abandons it
      repeat ($urandom_range(1, 5)) send_rx(8'($urandom));
    end else if (choice < 22) begin
      // Corrupt reply, sometimes followed by the good one
      send_reply(op, addr, reg_addr, wval, rval, $urandom_range(0, 7));
      if ($urandom_range(0, 1)) send_reply(op, addr, reg_addr, wval, rval, -1);
    end else if (choice < 28) begin
      // Reply of the other kind, then the right one
      send_reply(op == mrm_pkg::OP_START_READ ? mrm_pkg::OP_START_WRITE
                                              : mrm_pkg::OP_START_READ,
                 addr, reg_addr, wval, rval, -1);
      send_reply(op, addr, reg_addr, wval, rval, -1);
    end else begin
      // Good reply, with leading noise that the window must slide past
      repeat ($urandom_range(0, 3)) send_rx(8'($urandom));
      send_reply(op, addr, reg_addr, wval, rval, -1);
    end
    // Stray bytes after the match are ignored while idle
    repeat ($urandom_range(0, 2)) send_rx(8'($urandom));
    if ($urandom_range(0, 19) == 0)
      send_item(OP_UNUSED, pick_byte(), pick_word(), pick_word(), pick_byte());
  endtask

  task automatic test_random_traffic();
    while (items_sent < 270) random_exchange();
  endtask

  // Tail of the run with no idling on either side
  task automatic test_calm_traffic();
    calm = 1'b1;
    while (items_sent < 335) random_exchange();
  endtask

  initial begin
    rst_ni                 = 1'b0;
    in_if.valid            = 1'b0;
    in_if.opcode           = mrm_pkg::OP_RX_BYTE;
    in_if.slave_address    = '0;
    in_if.register_address = '0;
    in_if.write_value      = '0;
    in_if.rx_byte          = '0;
    calm                   = 1'b0;
    sender_bursty          = 1'b1;
    receiver_bursty        = 1'b1;
    hold_cycles            = 0;
    errors                 = 0;
    items_sent             = 0;
    tx_beats               = 0;
    read_acks              = 0;
    write_acks             = 0;
    shadow_mode            = WAIT_IDLE;
    shadow_request         = '0;
    shadow_window          = '0;
    shadow_fill            = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_ignored_items();
    test_read_exchange();
    test_write_exchange();
    test_restart();
    test_backpressure();
    test_random_traffic();
    test_calm_traffic();
    drain_results();

    // Anything still owed never came out
    while (awaited_beats.size() != 0) begin
      void'(awaited_beats.pop_front());
      report_mismatch("expected beat never arrived");
    end

    $display("Run covered %0d input items: %0d request beats, %0d read replies, %0d write echoes.",
             items_sent, tx_beats, read_acks, write_acks);
    $display("Mismatches counted: %0d", errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- modbus_rtu_register_master.f -----
rtl/mrm_pkg.sv
rtl/mrm_if.sv
rtl/mrm_out_buf.sv
rtl/modbus_rtu_register_master.sv
dv/tb.sv
